@@ sv/p2b_pkg.sv @@
package p2b_pkg;

	// Clamp limits of the source image
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

	// Pixel addresses are kept modulo 2^20: word_index needs bits 19..4 only
	localparam int PIX_W  = 20;
	localparam int WORD_W = 16;

	// One classified source byte: up to two masked writes, the second one
	// always lands in the word after the first.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [31:0]       data0;
		logic [31:0]       mask0;
		logic [31:0]       data1;
		logic [31:0]       mask1;
		logic              two;
		logic              eoi;
	} entry_t;

endpackage

@@ sv/p2b_if.sv @@
interface p2b_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface p2b_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] word_index;
	logic [31:0] write_data;
	logic [31:0] write_mask;
	logic        last_of_item;
	logic        end_of_image;

	modport source (output valid, output word_index, output write_data, output write_mask,
		output last_of_item, output end_of_image, input ready);
	modport sink (input valid, input word_index, input write_data, input write_mask,
		input last_of_item, input end_of_image, output ready);
endinterface

@@ sv/packed_2bpp_clipped_blit.sv @@
// Channel     Dir  Modport  Payload
// ----------  ---  -------  -------------------------------------------------------
// in_bytes    in   sink     source_byte[7:0]
// out_writes  out  source   word_index[15:0] write_data[31:0] write_mask[31:0]
//                           last_of_item end_of_image
// cfg         in   -        cfg_we, cfg_index[2:0], cfg_data[10:0]
//
// One source byte is accepted per cycle while in_bytes.ready is high; it leaves as
// one or two writes, one per cycle while out_writes.ready is high, and the output
// port sets the rate. An accepted byte is registered in two front stages, one around
// the row multiplier, then written to the queue, whose head drives the output.
// Reset is asynchronous and clears position, pipeline and queue; no sweep follows.
// Output stalls fill the 2-entry queue, then hold the front stages and in_bytes.ready.
module packed_2bpp_clipped_blit (
	input  logic                          clk,
	input  logic                          arst_n,
	p2b_in_if.sink                        in_bytes,
	p2b_out_if.source                     out_writes,
	input  logic                          cfg_we,
	input  logic [p2b_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2b_pkg::CFG_W-1:0]     cfg_data
);
	import p2b_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	// Front: hold the config, track the source position, clip each byte and
	// split it into per-word data and masks.
	p2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_bytes   (in_bytes),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Queue: decouple classification from write issue.
	p2b_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// Back: issue one or two masked writes per queued byte.
	p2b_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_writes (out_writes)
	);

endmodule

@@ sv/p2b_queue.sv @@
module p2b_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  p2b_pkg::entry_t push_entry,
	output logic            head_valid,
	output p2b_pkg::entry_t head_entry,
	input  logic            pop
);
	import p2b_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/p2b_front.sv @@
module p2b_front (
	input  logic                           clk,
	input  logic                           arst_n,
	p2b_in_if.sink                         in_bytes,
	input  logic                           cfg_we,
	input  logic [p2b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [p2b_pkg::CFG_W-1:0]      cfg_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output p2b_pkg::entry_t                push_entry
);
	import p2b_pkg::*;

	logic [10:0] dest_x_q, dest_y_q, image_width_q, image_height_q;
	logic [10:0] frame_width_q, frame_height_q;

	logic [7:0]  byte_column_q;
	logic [9:0]  source_row_q;

	logic [10:0] eff_w, eff_h;
	logic [11:0] w_plus3;
	logic [9:0]  row_bytes;
	logic        last_byte, eoi;
	logic [11:0] yy;
	logic        row_vis;
	logic        accept, cfg_hit;

	// stage 1: position and row classification
	logic        v_s1, vis_s1, eoi_s1;
	logic [7:0]  src_s1;
	logic [9:0]  col_s1;
	logic [10:0] yy_s1;
	// stage 2: row product
	logic        v_s2, vis_s2, eoi_s2;
	logic [7:0]  src_s2;
	logic [9:0]  col_s2;
	logic [PIX_W-1:0] prod_s2;

	logic [21:0] prod_full;
	logic        adv1, adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q       <= 11'd0;
			dest_y_q       <= 11'd0;
			image_width_q  <= 11'd4;
			image_height_q <= 11'd1;
			frame_width_q  <= 11'd320;
			frame_height_q <= 11'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEST_X:       dest_x_q       <= cfg_data;
				CFG_DEST_Y:       dest_y_q       <= cfg_data;
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_hit = cfg_we && (cfg_index <= CFG_FRAME_HEIGHT);

	// clamp the image size
	assign eff_w = (image_width_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width_q;
	always_comb begin
		if (image_height_q > 11'(MAX_HEIGHT)) begin
			eff_h = 11'(MAX_HEIGHT);
		end else if (image_height_q == 11'd0) begin
			eff_h = 11'd1;
		end else begin
			eff_h = image_height_q;
		end
	end
	assign w_plus3   = {1'b0, eff_w} + 12'd3;
	assign row_bytes = (w_plus3[11:2] == 10'd0) ? 10'd1 : w_plus3[11:2];
	assign last_byte = ({2'b00, byte_column_q} + 10'd1) >= row_bytes;
	assign eoi       = last_byte && (({1'b0, source_row_q} + 11'd1) >= eff_h);

	assign yy      = {dest_y_q[10], dest_y_q} + {2'b00, source_row_q};
	assign row_vis = !yy[11] && (yy[10:0] < frame_height_q);

	assign adv2            = !v_s2 || push_ready;
	assign adv1            = !v_s1 || adv2;
	assign in_bytes.ready  = adv1;
	assign accept          = in_bytes.valid && adv1;

	// advance the source position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_column_q <= 8'd0;
			source_row_q  <= 10'd0;
		end else if (cfg_hit) begin
			byte_column_q <= 8'd0;
			source_row_q  <= 10'd0;
		end else if (accept) begin
			if (eoi) begin
				byte_column_q <= 8'd0;
				source_row_q  <= 10'd0;
			end else if (last_byte) begin
				byte_column_q <= 8'd0;
				source_row_q  <= source_row_q + 10'd1;
			end else begin
				byte_column_q <= byte_column_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_bytes.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= in_bytes.source_byte;
			col_s1 <= {byte_column_q, 2'b00};
			yy_s1  <= yy[10:0];
			vis_s1 <= row_vis;
			eoi_s1 <= eoi;
		end
		if (adv2 && v_s1) begin
			src_s2  <= src_s1;
			col_s2  <= col_s1;
			vis_s2  <= vis_s1;
			eoi_s2  <= eoi_s1;
			prod_s2 <= prod_full[PIX_W-1:0];
		end
	end

	assign prod_full = yy_s1 * frame_width_q;

	// classify the four pixels against the clip window and the word grid
	logic [PIX_W-1:0]  p0;
	logic [WORD_W-1:0] a_word;
	logic [9:0]        c_k   [4];
	logic [11:0]       xx_k  [4];
	logic [4:0]        pos_k [4];
	logic [3:0]        sh_k  [4];
	logic [31:0]       dat_k [4];
	logic [31:0]       msk_k [4];
	logic [3:0]        vis_k, hi_k, g0, g1;
	logic [31:0]       d0, m0, d1, m1;

	assign p0     = prod_s2 + {{(PIX_W-11){dest_x_q[10]}}, dest_x_q} + {10'd0, col_s2};
	assign a_word = p0[PIX_W-1:4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			c_k[k]   = {col_s2[9:2], 2'(k)};
			xx_k[k]  = {dest_x_q[10], dest_x_q} + {2'b00, c_k[k]};
			vis_k[k] = vis_s2 && ({1'b0, c_k[k]} < eff_w) && !xx_k[k][11]
				&& (xx_k[k][10:0] < frame_width_q);
			pos_k[k] = {1'b0, p0[3:0]} + 5'(k);
			hi_k[k]  = pos_k[k][4];
			sh_k[k]  = 4'd15 - pos_k[k][3:0];
			dat_k[k] = {30'd0, src_s2[6-2*k +: 2]} << {sh_k[k], 1'b0};
			msk_k[k] = 32'h3 << {sh_k[k], 1'b0};
		end
	end

	assign g0 = vis_k & ~hi_k;
	assign g1 = vis_k & hi_k;

	always_comb begin
		d0 = 32'd0;
		m0 = 32'd0;
		d1 = 32'd0;
		m1 = 32'd0;
		for (int k = 0; k < 4; k++) begin
			if (g0[k]) begin
				d0 = d0 | dat_k[k];
				m0 = m0 | msk_k[k];
			end
			if (g1[k]) begin
				d1 = d1 | dat_k[k];
				m1 = m1 | msk_k[k];
			end
		end
	end

	always_comb begin
		push_entry.eoi   = eoi_s2;
		push_entry.data1 = d1;
		push_entry.mask1 = m1;
		if (|g0) begin
			push_entry.word  = a_word;
			push_entry.data0 = d0;
			push_entry.mask0 = m0;
			push_entry.two   = |g1;
		end else if (|g1) begin
			push_entry.word  = a_word + 16'd1;
			push_entry.data0 = d1;
			push_entry.mask0 = m1;
			push_entry.two   = 1'b0;
		end else begin
			push_entry.word  = '0;
			push_entry.data0 = 32'd0;
			push_entry.mask0 = 32'd0;
			push_entry.two   = 1'b0;
		end
	end

	assign push_valid = v_s2;

endmodule

@@ sv/p2b_back.sv @@
module p2b_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  p2b_pkg::entry_t head_entry,
	output logic            pop,
	p2b_out_if.source       out_writes
);
	import p2b_pkg::*;

	logic phase_q;
	logic last;
	logic fire;

	assign last = phase_q || !head_entry.two;
	assign fire = head_valid && out_writes.ready;
	assign pop  = fire && last;

	assign out_writes.valid        = head_valid;
	assign out_writes.word_index   = phase_q ? head_entry.word + WORD_W'(1) : head_entry.word;
	assign out_writes.write_data   = phase_q ? head_entry.data1 : head_entry.data0;
	assign out_writes.write_mask   = phase_q ? head_entry.mask1 : head_entry.mask0;
	assign out_writes.last_of_item = last;
	assign out_writes.end_of_image = head_entry.eoi;

	// step to the second write of a straddling byte, drop back after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (fire) begin
			phase_q <= !last;
		end
	end

endmodule

@@ sv/p2b_checker.sv @@
module p2b_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] word_index,
	input logic [31:0] write_data,
	input logic [31:0] write_mask,
	input logic        last_of_item,
	input logic        end_of_image
);

	// a stalled write holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_index)
			&& $stable(write_data) && $stable(write_mask))
		else $error("stalled write changed");

	// second write of a byte follows at once, in the next word
	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid
			&& word_index == $past(word_index) + 16'd1)
		else $error("second write missing or not in next word");

	// both writes of a byte agree on end of image
	a_eoi_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> end_of_image == $past(end_of_image))
		else $error("end_of_image differs within a byte");

	// data only under the mask
	a_data_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_data & ~write_mask) == 32'd0)
		else $error("data outside mask");

	// mask covers whole pixels
	a_mask_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((write_mask ^ (write_mask >> 1)) & 32'h5555_5555) == 32'd0)
		else $error("mask splits a pixel");

endmodule

bind packed_2bpp_clipped_blit p2b_checker u_p2b_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_writes.valid),
	.out_ready    (out_writes.ready),
	.word_index   (out_writes.word_index),
	.write_data   (out_writes.write_data),
	.write_mask   (out_writes.write_mask),
	.last_of_item (out_writes.last_of_item),
	.end_of_image (out_writes.end_of_image)
);
